FILE: rtl/core/sfs_pkg.sv
package sfs_pkg;

  localparam int TEXT_ADDR_BITS_DEF = 20;
  localparam int DEPTH_BITS_DEF     = 16;

  // Byte codes the parser reacts to
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Result kinds
  localparam logic [1:0] KIND_FORM      = 2'd0;
  localparam logic [1:0] KIND_NO_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_STRAY     = 2'd2;
  localparam logic [1:0] KIND_END       = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAYOUT_LO   = 2'd0;
  localparam logic [1:0] CFG_LAYOUT_HI   = 2'd1;
  localparam logic [1:0] CFG_BOUNDARY_LO = 2'd2;
  localparam logic [1:0] CFG_BOUNDARY_HI = 2'd3;

  // Default masks: tab, LF, VT, FF, CR, space are layout;
  // the same codes plus '(' and ')' are boundaries
  localparam logic [63:0] LAYOUT_LO_RST   = 64'h0000_0001_0000_3E00;
  localparam logic [63:0] LAYOUT_HI_RST   = 64'h0;
  localparam logic [63:0] BOUNDARY_LO_RST = 64'h0000_0301_0000_3E00;
  localparam logic [63:0] BOUNDARY_HI_RST = 64'h0;

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_COMMENT = 6'b000010,
    PH_BANG    = 6'b000100,
    PH_PAREN   = 6'b001000,
    PH_TOKEN   = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    TS_OUT = 4'b0001,
    TS_STR = 4'b0010,
    TS_ESC = 4'b0100,
    TS_COM = 4'b1000
  } text_state_t;

  function automatic text_state_t next_text_state(text_state_t ts, logic [7:0] c);
    text_state_t r;
    r = TS_OUT;
    unique case (ts)
      TS_OUT: r = (c == CH_DQUOTE) ? TS_STR : ((c == CH_SEMI) ? TS_COM : TS_OUT);
      TS_STR: r = (c == CH_BSLASH) ? TS_ESC : ((c == CH_DQUOTE) ? TS_OUT : TS_STR);
      TS_ESC: r = TS_STR;
      TS_COM: r = (c == CH_LF) ? TS_OUT : TS_COM;
      default: r = TS_OUT;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/sfs_resq.sv
module sfs_resq
  import sfs_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   push_cnt,
  input  logic [W-1:0] push_d0,
  input  logic [W-1:0] push_d1,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int DEPTH = 3;

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] q_r   [DEPTH];
  logic [W-1:0] q_nxt [DEPTH];
  logic         pop;
  logic [1:0]   base;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign base      = cnt_r - {1'b0, pop};
  assign room      = (base <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign cnt_nxt   = base + push_cnt;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % DEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push_cnt != 2'd0) && (base == 2'(i))) begin
        q_nxt[i] = push_d0;
      end
      if ((push_cnt == 2'd2) && ((base + 2'd1) == 2'(i))) begin
        q_nxt[i] = push_d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> ({1'b0, base} + {1'b0, push_cnt} <= 3'(DEPTH)))
    else $error("result queue overflow");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) && pop && (push_cnt == 2'd0) |=> (cnt_r == 2'd0))
    else $error("result queue failed to drain");

endmodule

FILE: rtl/core/sexpr_form_splitter.sv
// A byte's results reach out_ through the input register, then the result
// queue register; while the queue has no room the byte waits in the input register.
// Throughput: one byte per cycle while the result queue has room; the per-byte
// parse step is a single pass of logic. Only a byte that ends the text, or a
// stray boundary byte right after a bare token, can give two results; the
// second waits behind the first in the three-entry result queue.
// Reset (rst_n low at a clock edge): parse state cleared, masks to defaults.
module sexpr_form_splitter
  import sfs_pkg::*;
#(
  parameter int TEXT_ADDR_BITS = TEXT_ADDR_BITS_DEF,
  parameter int DEPTH_BITS     = DEPTH_BITS_DEF,
  localparam int PW            = TEXT_ADDR_BITS + 1,
  localparam int RAW_W         = 3 * PW + 1,
  localparam int TDW           = ((RAW_W + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  // in_tdata: data_byte[7:0]
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tlast,
  // out_tdata: start_offset, end_offset, start_line, is_runnable (low to high)
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [TDW-1:0] out_tdata,
  // out_tuser: result_kind
  output logic [1:0]     out_tuser,
  output logic           out_tlast,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_wdata
);

  localparam logic [PW-1:0]         POS_MAX   = {1'b1, {TEXT_ADDR_BITS{1'b0}}};
  localparam logic [PW-1:0]         POS_ONE   = PW'(1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  typedef struct packed {
    logic          last;
    logic [1:0]    kind;
    logic          run;
    logic [PW-1:0] line;
    logic [PW-1:0] eo;
    logic [PW-1:0] so;
  } res_t;

  function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
    return v[PW-1] ? POS_MAX : v + POS_ONE;
  endfunction

  function automatic res_t mk_res(logic [1:0] k, logic [PW-1:0] s, logic [PW-1:0] e,
                                  logic [PW-1:0] l, logic r);
    res_t x;
    x.last = 1'b0;
    x.kind = k;
    x.run  = r;
    x.line = l;
    x.eo   = e;
    x.so   = s;
    return x;
  endfunction

  // Configuration
  logic [127:0] lay_r, bnd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lay_r <= {LAYOUT_HI_RST, LAYOUT_LO_RST};
      bnd_r <= {BOUNDARY_HI_RST, BOUNDARY_LO_RST};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LAYOUT_LO:   lay_r[63:0]   <= cfg_wdata;
        CFG_LAYOUT_HI:   lay_r[127:64] <= cfg_wdata;
        CFG_BOUNDARY_LO: bnd_r[63:0]   <= cfg_wdata;
        CFG_BOUNDARY_HI: bnd_r[127:64] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_v_r;
  logic [7:0] c_r;
  logic       eot_r;
  logic       room;
  logic       proc_go;

  assign proc_go   = in_v_r && room;
  assign in_tready = !in_v_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (proc_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      c_r   <= in_tdata;
      eot_r <= in_tlast;
    end
  end

  // Parse state
  phase_t              ph_r, ph_nxt;
  text_state_t         ts_r, ts_nxt;
  logic [DEPTH_BITS-1:0] dep_r, dep_nxt;
  logic [PW-1:0]       bo_r, bo_nxt;
  logic [PW-1:0]       lc_r, lc_nxt;
  logic [PW-1:0]       fb_r, fb_nxt;
  logic [PW-1:0]       fl_r, fl_nxt;
  logic                pend_r, pend_nxt;

  logic        is_lay, is_bnd, bang_bnd;
  logic        go_tok, go_btw;
  text_state_t ts_w;
  logic [1:0]  nh;
  res_t        rs [2];

  assign is_lay   = !c_r[7] && lay_r[c_r[6:0]];
  assign is_bnd   = !c_r[7] && bnd_r[c_r[6:0]];
  assign bang_bnd = bnd_r[CH_BANG[6:0]];

  always_comb begin
    ph_nxt   = ph_r;
    ts_nxt   = ts_r;
    dep_nxt  = dep_r;
    bo_nxt   = bo_r;
    lc_nxt   = lc_r;
    fb_nxt   = fb_r;
    fl_nxt   = fl_r;
    pend_nxt = pend_r;
    go_tok   = 1'b0;
    go_btw   = 1'b0;
    ts_w     = ts_r;
    nh       = 2'd0;
    rs[0]    = '0;
    rs[1]    = '0;

    if (ph_r != PH_HALT) begin
      unique case (ph_r)
        PH_COMMENT: begin
          if (c_r == CH_LF) ph_nxt = PH_BETWEEN;
        end
        PH_BANG: begin
          if ((c_r == CH_LPAREN) || is_lay) begin
            pend_nxt = 1'b1;
            go_btw   = 1'b1;
          end else if (bang_bnd) begin
            rs[0]  = mk_res(KIND_STRAY, fb_r, fb_r, fl_r, pend_r);
            nh     = 2'd1;
            ph_nxt = PH_HALT;
          end else begin
            // the marker becomes the first byte of a bare token
            go_tok = 1'b1;
            ts_w   = TS_OUT;
          end
        end
        PH_TOKEN: begin
          go_tok = 1'b1;
        end
        PH_PAREN: begin
          if (ts_r == TS_OUT) begin
            if ((c_r == CH_LPAREN) && (dep_r != DEPTH_MAX)) begin
              dep_nxt = dep_r + 1'b1;
            end else if ((c_r == CH_RPAREN) && (dep_r != '0)) begin
              dep_nxt = dep_r - 1'b1;
            end
          end
          ts_nxt = next_text_state(ts_r, c_r);
          if ((dep_nxt == '0) && (ts_nxt == TS_OUT)) begin
            rs[0]    = mk_res(KIND_FORM, fb_r, sat_inc(bo_r), fl_r, pend_r);
            nh       = 2'd1;
            pend_nxt = 1'b0;
            ph_nxt   = PH_BETWEEN;
          end
        end
        PH_BETWEEN: begin
          go_btw = 1'b1;
        end
        default: ;
      endcase

      if (go_tok) begin
        if ((ts_w == TS_OUT) && is_bnd) begin
          // token ends before this byte; handle the byte again between forms
          rs[0]    = mk_res(KIND_FORM, fb_r, bo_r, fl_r, pend_nxt);
          nh       = 2'd1;
          pend_nxt = 1'b0;
          go_btw   = 1'b1;
        end else begin
          ts_nxt = next_text_state(ts_w, c_r);
          ph_nxt = PH_TOKEN;
        end
      end

      if (go_btw) begin
        if (c_r == CH_SEMI) begin
          ph_nxt = PH_COMMENT;
        end else if (is_lay) begin
          ph_nxt = PH_BETWEEN;
        end else if ((c_r == CH_BANG) && !pend_nxt) begin
          ph_nxt = PH_BANG;
          fb_nxt = bo_r;
          fl_nxt = lc_r;
        end else begin
          fb_nxt = bo_r;
          fl_nxt = lc_r;
          if (c_r == CH_LPAREN) begin
            ph_nxt  = PH_PAREN;
            dep_nxt = DEPTH_BITS'(1);
            ts_nxt  = TS_OUT;
          end else if (is_bnd) begin
            rs[nh[0]] = mk_res(KIND_STRAY, bo_r, bo_r, lc_r, pend_nxt);
            nh        = nh + 2'd1;
            ph_nxt    = PH_HALT;
          end else begin
            ph_nxt = PH_TOKEN;
            ts_nxt = next_text_state(TS_OUT, c_r);
          end
        end
      end

      if (c_r == CH_LF) lc_nxt = sat_inc(lc_r);
      bo_nxt = sat_inc(bo_r);

      if (eot_r) begin
        if (ph_nxt == PH_TOKEN) begin
          if (nh != 2'd2) begin
            rs[nh[0]] = mk_res(KIND_FORM, fb_nxt, bo_nxt, fl_nxt, pend_nxt);
            nh        = nh + 2'd1;
          end
          if (nh != 2'd2) begin
            rs[nh[0]] = mk_res(KIND_END, bo_nxt, bo_nxt, lc_nxt, 1'b0);
            nh        = nh + 2'd1;
          end
        end else if (ph_nxt == PH_PAREN) begin
          if (nh != 2'd2) begin
            rs[nh[0]] = mk_res(KIND_NO_CLOSE, fb_nxt, bo_nxt, fl_nxt, pend_nxt);
            nh        = nh + 2'd1;
          end
        end else if (ph_nxt != PH_HALT) begin
          if (nh != 2'd2) begin
            rs[nh[0]] = mk_res(KIND_END, bo_nxt, bo_nxt, lc_nxt, 1'b0);
            nh        = nh + 2'd1;
          end
        end
        ph_nxt = PH_HALT;
      end
    end

    // mark the final result of this byte
    if (nh == 2'd1) rs[0].last = 1'b1;
    if (nh == 2'd2) rs[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_BETWEEN;
      ts_r   <= TS_OUT;
      dep_r  <= '0;
      bo_r   <= '0;
      lc_r   <= POS_ONE;
      fb_r   <= '0;
      fl_r   <= POS_ONE;
      pend_r <= 1'b0;
    end else if (proc_go) begin
      ph_r   <= ph_nxt;
      ts_r   <= ts_nxt;
      dep_r  <= dep_nxt;
      bo_r   <= bo_nxt;
      lc_r   <= lc_nxt;
      fb_r   <= fb_nxt;
      fl_r   <= fl_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Result queue
  res_t q_out;

  sfs_resq #(
    .W ($bits(res_t))
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (proc_go ? nh : 2'd0),
    .push_d0   (rs[0]),
    .push_d1   (rs[1]),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = TDW'({q_out.run, q_out.line, q_out.eo, q_out.so});
  assign out_tuser = q_out.kind;
  assign out_tlast = q_out.last;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_HALT) |=> (ph_r == PH_HALT))
    else $error("parser left the halted phase");

  a_paren_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PAREN) |-> (dep_r != '0))
    else $error("open form with zero depth");

  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && (ph_r != PH_HALT) && !bo_r[PW-1] |=> (bo_r == $past(bo_r) + POS_ONE))
    else $error("byte offset did not advance");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(ph_r) && $onehot(ts_r))
    else $error("phase or text state code corrupted");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_HALT) |-> (nh == 2'd0))
    else $error("result produced after halt");

endmodule
